// ===== sv/bga_pkg.sv =====
// Shared types and constants for the battery gauge averager.
// No dependencies; every other file refers to this package by scoped names.
package bga_pkg;

    localparam int ELAPSED_W  = 24;
    localparam int ADC_W      = 12;
    localparam int SUM_W      = 18;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int LVL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int OFFSET_W   = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_HW_REVISION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd2;

    localparam logic [ELAPSED_W-1:0] INTERVAL_RESET = 24'd250000;

    // Revision 0 line: r : 720..920 -> 3700..4500 reduces to 4*r + 820
    localparam logic [MV_W-1:0] REV0_BIAS = 16'd820;
    // Revision 1 line: 4*r : 3780..5030 -> 3600..4600, slope 4/5
    localparam logic signed [19:0] REV1_IN_LO = 20'sd3780;
    localparam logic [MV_W-1:0]    REV1_OUT_LO = 16'd3600;
    // Reciprocal of 5 scaled by 2^22, exact for 20-bit dividends
    localparam int               DIV5_SHIFT = 22;
    localparam logic [19:0]      DIV5_MULT  = 20'd838861;

    // Percentage line: mv : 3700..4500 -> 0..100 reduces to (mv - 3700) / 8
    localparam logic signed [16:0] PCT_MV_LO = 17'sd3700;
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;

    localparam logic [PCT_W-1:0] LVL5_ABOVE = 7'd80;
    localparam logic [PCT_W-1:0] LVL4_ABOVE = 7'd60;
    localparam logic [PCT_W-1:0] LVL3_ABOVE = 7'd40;
    localparam logic [PCT_W-1:0] LVL2_ABOVE = 7'd20;
    localparam logic [PCT_W-1:0] LVL1_FROM  = 7'd5;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic [LVL_W-1:0] level;
    } gauge_t;

endpackage

// ===== sv/bga_if.sv =====
// Handshake channels of the battery gauge averager: tick in, result out, config.
// Depends on bga_pkg for field widths.
interface bga_tick_if;
    logic                           valid;
    logic                           ready;
    logic [bga_pkg::ELAPSED_W-1:0]  elapsed_us;
    logic [bga_pkg::ADC_W-1:0]      adc_sample;

    modport source (output valid, output elapsed_us, output adc_sample, input ready);
    modport sink   (input valid, input elapsed_us, input adc_sample, output ready);
endinterface

interface bga_result_if;
    logic                       valid;
    logic                       ready;
    logic [bga_pkg::MV_W-1:0]   battery_mv;
    logic [bga_pkg::PCT_W-1:0]  charge_percent;
    logic [bga_pkg::LVL_W-1:0]  charge_level;
    logic                       average_updated;

    modport source (output valid, output battery_mv, output charge_percent,
                    output charge_level, output average_updated, input ready);
    modport sink   (input valid, input battery_mv, input charge_percent,
                    input charge_level, input average_updated, output ready);
endinterface

interface bga_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bga_pkg::CFG_IDX_W-1:0]  index;
    logic [bga_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/bga_gauge.sv =====
// Charge percentage and five-step level from a millivolt reading.
// Combinational; depends on bga_pkg for constants and gauge_t.
module bga_gauge
(
    input  logic [bga_pkg::MV_W-1:0] mv,
    output bga_pkg::gauge_t          gauge
);

    logic signed [16:0]         span;
    logic [12:0]                eighths;
    logic [bga_pkg::PCT_W-1:0]  pct;

    assign span    = $signed({1'b0, mv}) - bga_pkg::PCT_MV_LO;
    assign eighths = span[15:3];

    always_comb
    begin
        // Truncation toward zero leaves small negative spans at 0, so clamp all of them
        if (span <= 17'sd0)
        begin
            pct = '0;
        end
        else if (eighths > 13'(bga_pkg::PCT_MAX))
        begin
            pct = bga_pkg::PCT_MAX;
        end
        else
        begin
            pct = eighths[bga_pkg::PCT_W-1:0];
        end
    end

    always_comb
    begin
        gauge.percent = pct;
        priority if (pct > bga_pkg::LVL5_ABOVE)
        begin
            gauge.level = 3'd5;
        end
        else if (pct > bga_pkg::LVL4_ABOVE)
        begin
            gauge.level = 3'd4;
        end
        else if (pct > bga_pkg::LVL3_ABOVE)
        begin
            gauge.level = 3'd3;
        end
        else if (pct > bga_pkg::LVL2_ABOVE)
        begin
            gauge.level = 3'd2;
        end
        else if (pct >= bga_pkg::LVL1_FROM)
        begin
            gauge.level = 3'd1;
        end
        else
        begin
            gauge.level = 3'd0;
        end
    end

endmodule

// ===== sv/battery_gauge_averager.sv =====
// Battery gauge averager: one result per tick transfer; one tick accepted and one
// result delivered every cycle while the result side is not stalling.
// Five register stages with per-stage valid bits; a stall at the output only
// backs up stages that are full. Depth is set by the two reciprocal multiplies.
// Reset (rst_n low, asynchronous) empties the pipe, clears the accumulators and
// the average, and loads the registers with revision 0, offset 0, 250000 us.
module battery_gauge_averager
#(
    parameter int SAMPLES_PER_AVERAGE = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    bga_tick_if.sink     tick,
    bga_result_if.source result,
    bga_cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int AVG_K = bga_pkg::SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int MUL_W = AVG_K + 1;
    localparam logic [63:0] AVG_MULT =
        ((64'd1 << AVG_K) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);

    // Configuration
    logic                               rev_reg;
    logic signed [bga_pkg::OFFSET_W-1:0] off_reg;
    logic [bga_pkg::ELAPSED_W-1:0]      interval_reg;

    // Averaging state; avg_sum_reg is the sum behind the current average
    logic [bga_pkg::ELAPSED_W-1:0]      accum_reg, accum_next;
    logic [bga_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [bga_pkg::SUM_W-1:0]          avg_sum_reg, avg_sum_next;

    // Pipe valid bits and stage readiness
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    // Stage payloads
    logic [bga_pkg::ELAPSED_W-1:0]  p1_elapsed_reg;
    logic [bga_pkg::ADC_W-1:0]      p1_sample_reg;
    logic [bga_pkg::SUM_W-1:0]      p2_snap_reg;
    logic                           p2_upd_reg, upd_next;
    logic [bga_pkg::ADC_W-1:0]      p3_avg_reg;
    logic                           p3_upd_reg;
    logic                           p4_rev_reg, p4_neg_reg, p4_upd_reg;
    logic [39:0]                    p4_prod_reg;
    logic [bga_pkg::MV_W-1:0]       p4_mv0_reg;
    logic [bga_pkg::MV_W-1:0]       mv_reg;
    logic                           upd_reg;
    bga_pkg::gauge_t                gauge_reg;

    // Stage combinational signals
    logic [bga_pkg::ELAPSED_W:0]    accum_sum;
    logic                           due;
    logic [bga_pkg::SUM_W-1:0]      sum_inc;
    logic [CNT_W-1:0]               cnt_inc;
    logic [bga_pkg::SUM_W+MUL_W-1:0] avg_prod;
    logic [bga_pkg::MV_W-1:0]       rev1_in;
    logic signed [19:0]             rev1_span;
    logic [17:0]                    rev1_mag;
    logic [19:0]                    rev1_num;
    logic [39:0]                    rev1_prod;
    logic [bga_pkg::MV_W-1:0]       mv0;
    logic [bga_pkg::MV_W-1:0]       q16;
    logic [bga_pkg::MV_W-1:0]       mv_next;
    bga_pkg::gauge_t                gauge_next;

    assign r5 = !v5_reg || result.ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;

    assign tick.ready = r1;
    assign cfg.ready  = 1'b1;

    // Time accumulation and sample summing for the tick leaving stage 1
    always_comb
    begin
        accum_sum    = {1'b0, accum_reg} + {1'b0, p1_elapsed_reg};
        due          = accum_sum >= {1'b0, interval_reg};
        sum_inc      = sum_reg + bga_pkg::SUM_W'(p1_sample_reg);
        cnt_inc      = cnt_reg + CNT_W'(1);
        accum_next   = accum_sum[bga_pkg::ELAPSED_W-1:0];
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        avg_sum_next = avg_sum_reg;
        upd_next     = 1'b0;
        if (due)
        begin
            accum_next = '0;
            if (cnt_inc == CNT_W'(SAMPLES_PER_AVERAGE))
            begin
                avg_sum_next = sum_inc;
                sum_next     = '0;
                cnt_next     = '0;
                upd_next     = 1'b1;
            end
            else
            begin
                sum_next = sum_inc;
                cnt_next = cnt_inc;
            end
        end
    end

    // Mean by reciprocal multiply, exact over the whole sum range
    assign avg_prod = {{MUL_W{1'b0}}, p2_snap_reg}
                    * {{bga_pkg::SUM_W{1'b0}}, AVG_MULT[MUL_W-1:0]};

    // Millivolt maps from the average
    always_comb
    begin
        rev1_in   = bga_pkg::MV_W'(p3_avg_reg) + off_reg;
        rev1_span = $signed({2'b00, rev1_in, 2'b00}) - bga_pkg::REV1_IN_LO;
        rev1_mag  = rev1_span[19] ? 18'(-rev1_span) : rev1_span[17:0];
        rev1_num  = {rev1_mag, 2'b00};
        rev1_prod = {20'd0, rev1_num} * {20'd0, bga_pkg::DIV5_MULT};
        mv0       = {p3_avg_reg, 2'b00} + bga_pkg::REV0_BIAS + off_reg;
    end

    // Quotient toward zero, then wrap to 16 bits
    assign q16     = p4_prod_reg[bga_pkg::DIV5_SHIFT +: bga_pkg::MV_W];
    assign mv_next = p4_rev_reg
                   ? bga_pkg::REV1_OUT_LO + (p4_neg_reg ? -q16 : q16)
                   : p4_mv0_reg;

    bga_gauge u_gauge
    (
        .mv    (mv_next),
        .gauge (gauge_next)
    );

    // Control state, configuration and averaging state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            rev_reg      <= 1'b0;
            off_reg      <= '0;
            interval_reg <= bga_pkg::INTERVAL_RESET;
            accum_reg    <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            avg_sum_reg  <= '0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= tick.valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
            if (r4)
            begin
                v4_reg <= v3_reg;
            end
            if (r5)
            begin
                v5_reg <= v4_reg;
            end
            // Advance the averaging state only as a tick moves on
            if (v1_reg && r2)
            begin
                accum_reg   <= accum_next;
                sum_reg     <= sum_next;
                cnt_reg     <= cnt_next;
                avg_sum_reg <= avg_sum_next;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    bga_pkg::REG_HW_REVISION:     rev_reg      <= cfg.data[0];
                    bga_pkg::REG_VOLT_OFFSET:     off_reg      <= cfg.data[bga_pkg::OFFSET_W-1:0];
                    bga_pkg::REG_SAMPLE_INTERVAL: interval_reg <= cfg.data;
                    default:                      ;
                endcase
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (r1 && tick.valid)
        begin
            p1_elapsed_reg <= tick.elapsed_us;
            p1_sample_reg  <= tick.adc_sample;
        end
        if (r2 && v1_reg)
        begin
            p2_snap_reg <= avg_sum_next;
            p2_upd_reg  <= upd_next;
        end
        if (r3 && v2_reg)
        begin
            p3_avg_reg <= avg_prod[AVG_K +: bga_pkg::ADC_W];
            p3_upd_reg <= p2_upd_reg;
        end
        if (r4 && v3_reg)
        begin
            p4_rev_reg  <= rev_reg;
            p4_neg_reg  <= rev1_span[19];
            p4_prod_reg <= rev1_prod;
            p4_mv0_reg  <= mv0;
            p4_upd_reg  <= p3_upd_reg;
        end
        if (r5 && v4_reg)
        begin
            mv_reg    <= mv_next;
            gauge_reg <= gauge_next;
            upd_reg   <= p4_upd_reg;
        end
    end

    assign result.valid           = v5_reg;
    assign result.battery_mv      = mv_reg;
    assign result.charge_percent  = gauge_reg.percent;
    assign result.charge_level    = gauge_reg.level;
    assign result.average_updated = upd_reg;

    a_count_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(SAMPLES_PER_AVERAGE))
        else $error("sample count reached the averaging length");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.charge_percent <= bga_pkg::PCT_MAX)
        else $error("charge percentage above full scale");

    a_empty_takes_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> tick.ready)
        else $error("empty input stage refused a tick");

    a_update_flag_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && r2 && upd_next) |=> (v2_reg && p2_upd_reg))
        else $error("completed average lost its update flag");

endmodule

// ===== verif/bga_gauge_tb_pkg.sv =====
`timescale 1ns / 100ps
// Checking side of the battery gauge averager testbench: expected-reading type,
// mapping constants and the gauge scoreboard. Depends on bga_pkg.
package bga_gauge_tb_pkg;

    localparam int AVG_SAMPLES = 8;

    // No register sits at this index; writes to it must change nothing
    localparam logic [bga_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Revision 0 line: reading 720..920 -> 3700..4500 mV
    localparam longint REV0_LO    = 720;
    localparam longint REV0_HI    = 920;
    localparam longint REV0_MV_LO = 3700;
    localparam longint REV0_MV_HI = 4500;
    // Revision 1 line: 4 * reading 3780..5030 -> 3600..4600 mV
    localparam longint REV1_LO    = 3780;
    localparam longint REV1_HI    = 5030;
    localparam longint REV1_MV_LO = 3600;
    localparam longint REV1_MV_HI = 4600;
    // Percentage line: 3700..4500 mV -> 0..100
    localparam longint PCT_MV_LO  = 3700;
    localparam longint PCT_MV_HI  = 4500;
    localparam longint PCT_FULL   = 100;

    typedef struct packed {
        logic [bga_pkg::MV_W-1:0]  mv;
        logic [bga_pkg::PCT_W-1:0] percent;
        logic [bga_pkg::LVL_W-1:0] level;
        logic                      updated;
    } gauge_reading_t;

    class gauge_scoreboard;
        bit                             hw_rev;
        logic signed [15:0]             offset;
        logic [23:0]                    interval;
        logic [31:0]                    time_acc;
        logic [17:0]                    sample_sum;
        logic [5:0]                     sample_cnt;
        logic [11:0]                    avg_reading;
        gauge_reading_t                 readings_due[$];
        int                             mismatches;

        function new();
            hw_rev      = 1'b0;
            offset      = '0;
            interval    = bga_pkg::INTERVAL_RESET;
            time_acc    = '0;
            sample_sum  = '0;
            sample_cnt  = '0;
            avg_reading = '0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [bga_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
            case (idx)
                bga_pkg::REG_HW_REVISION:     hw_rev = data[0];
                bga_pkg::REG_VOLT_OFFSET:     offset = data[15:0];
                bga_pkg::REG_SAMPLE_INTERVAL: interval = data;
                default: ;
            endcase
        endfunction

        // Advance the averaging state by one tick and queue the reading it gives
        function void note_tick(logic [23:0] elapsed, logic [11:0] sample);
            gauge_reading_t due;
            logic [15:0]    biased;
            longint         line_mv;
            longint         pct;
            due.updated = 1'b0;
            time_acc = time_acc + 32'(elapsed);
            if (time_acc >= 32'(interval))
            begin
                time_acc   = '0;
                sample_sum = sample_sum + 18'(sample);
                sample_cnt = sample_cnt + 6'd1;
                if (sample_cnt == 6'(AVG_SAMPLES))
                begin
                    avg_reading = 12'(sample_sum / AVG_SAMPLES);
                    sample_sum  = '0;
                    sample_cnt  = '0;
                    due.updated = 1'b1;
                end
            end

            if (hw_rev)
            begin
                // offset goes in before the map, wrapping at 16 bits
                biased  = 16'(avg_reading) + offset;
                line_mv = (4 * longint'(biased) - REV1_LO) * (REV1_MV_HI - REV1_MV_LO)
                          / (REV1_HI - REV1_LO) + REV1_MV_LO;
                due.mv  = 16'(line_mv);
            end
            else
            begin
                line_mv = (longint'(avg_reading) - REV0_LO) * (REV0_MV_HI - REV0_MV_LO)
                          / (REV0_HI - REV0_LO) + REV0_MV_LO;
                due.mv  = 16'(line_mv) + offset;
            end

            pct = (longint'(due.mv) - PCT_MV_LO) * PCT_FULL / (PCT_MV_HI - PCT_MV_LO);
            if (pct < 0)
                pct = 0;
            else if (pct > PCT_FULL)
                pct = PCT_FULL;
            due.percent = 7'(pct);

            if (pct > 80)
                due.level = 3'd5;
            else if (pct > 60)
                due.level = 3'd4;
            else if (pct > 40)
                due.level = 3'd3;
            else if (pct > 20)
                due.level = 3'd2;
            else if (pct >= 5)
                due.level = 3'd1;
            else
                due.level = 3'd0;

            readings_due.push_back(due);
        endfunction

        function void check_result(gauge_reading_t seen);
            gauge_reading_t due;
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected reading: mv %0d percent %0d level %0d updated %0d",
                         $time, seen.mv, seen.percent, seen.level, seen.updated);
                mismatches++;
                return;
            end
            due = readings_due.pop_front();
            if (seen.mv !== due.mv)
            begin
                $display("%0t: battery_mv expected %0d actual %0d", $time, due.mv, seen.mv);
                mismatches++;
            end
            if (seen.percent !== due.percent)
            begin
                $display("%0t: charge_percent expected %0d actual %0d",
                         $time, due.percent, seen.percent);
                mismatches++;
            end
            if (seen.level !== due.level)
            begin
                $display("%0t: charge_level expected %0d actual %0d",
                         $time, due.level, seen.level);
                mismatches++;
            end
            if (seen.updated !== due.updated)
            begin
                $display("%0t: average_updated expected %0d actual %0d",
                         $time, due.updated, seen.updated);
                mismatches++;
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

endpackage

// ===== verif/tb_battery_gauge_averager.sv =====
`timescale 1ns / 100ps
// Top-level testbench of battery_gauge_averager: drives ticks and register writes,
// stalls the result side, checks every reading. Depends on bga_pkg, bga_if.sv, bga_gauge_tb_pkg.
module tb_battery_gauge_averager;

    localparam int          RANDOM_PHASES    = 6;
    localparam int          ITEMS_PER_PHASE  = 84;
    localparam int          LONG_HOLD_CYCLES = 80;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT      = 200000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    bit                                allow_idle = 1'b1;
    int                                hold_requests = 0;
    int                                holds_served = 0;
    int                                hold_left = 0;
    int                                stall_left = 0;
    int unsigned                       cycles_run = 0;
    bga_gauge_tb_pkg::gauge_scoreboard gauge;

    bga_tick_if   tick_ch();
    bga_result_if result_ch();
    bga_cfg_if    cfg_ch();

    battery_gauge_averager #(.SAMPLES_PER_AVERAGE(bga_gauge_tb_pkg::AVG_SAMPLES)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("tb_battery_gauge_averager NOT OK");
            $finish;
        end
    end

    // Result side: a requested long hold first, then random stall bursts
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_served)
        begin
            result_ch.ready <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left <= LONG_HOLD_CYCLES - 1;
        end
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            gauge.check_result({result_ch.battery_mv, result_ch.charge_percent,
                                result_ch.charge_level, result_ch.average_updated});
    end

    // Leaves valid high after the transfer so back-to-back ticks need no toggle
    task automatic send_tick(input logic [23:0] elapsed, input logic [11:0] sample);
        int gap;
        gap = 0;
        if (allow_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 7);
        if (gap != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.elapsed_us <= elapsed;
        tick_ch.adc_sample <= sample;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        gauge.note_tick(elapsed, sample);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [bga_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        gauge.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_results_in();
        while (gauge.pending() != 0)
            @(negedge clk);
    endtask

    // Drop the tick stream, let the pipe empty, then rewrite all three registers
    task automatic program_gauge(input logic [23:0] rev_data, input logic [23:0] off_data,
                                 input logic [23:0] interval_data);
        tick_ch.valid <= 1'b0;
        wait_results_in();
        write_reg(bga_pkg::REG_HW_REVISION, rev_data);
        write_reg(bga_pkg::REG_VOLT_OFFSET, off_data);
        write_reg(bga_pkg::REG_SAMPLE_INTERVAL, interval_data);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic        rev;
        logic [15:0] off;
        logic [23:0] ivl;
        logic [23:0] el;
        logic [11:0] smp;

        gauge = new();
        tick_ch.valid      = 1'b0;
        tick_ch.elapsed_us = '0;
        tick_ch.adc_sample = '0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: the sample falls due exactly on the interval
        send_tick(24'd0, 12'd0);
        send_tick(24'd249999, 12'd100);
        send_tick(24'd1, 12'd200);
        send_tick(24'hFFFFFF, 12'hFFF);

        // Zero interval: every tick takes a sample; full scale then empty
        program_gauge(24'd0, 24'd0, 24'd0);
        @(negedge clk);
        write_reg(bga_gauge_tb_pkg::REG_SPARE, 24'hFFFFFF);
        cfg_ch.valid <= 1'b0;
        for (int n = 0; n < 6; n++)
            send_tick(24'd0, 12'hFFF);
        for (int n = 0; n < 8; n++)
            send_tick(24'($urandom), 12'd0);

        // Offset wrap on revision 1, both offset extremes, maximum interval
        program_gauge(24'd1, 24'h00FFFF, 24'd0);
        send_tick(24'd0, 12'd0);
        program_gauge(24'd1, 24'hA57FFF, 24'd0);
        send_tick(24'd0, 12'hFFF);
        program_gauge(24'hFFFFFE, 24'h008000, 24'd0);
        send_tick(24'd5, 12'd1);
        program_gauge(24'd1, 24'd0, 24'hFFFFFF);
        send_tick(24'hFFFFFF, 12'hFFF);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            rev = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0)
                off = 16'($urandom);
            else
                off = 16'($urandom_range(0, 400) - 200);
            case ($urandom_range(0, 9))
                0:       ivl = 24'd0;
                1:       ivl = 24'hFFFFFF;
                2:       ivl = 24'($urandom);
                default: ivl = 24'($urandom_range(1, 2000));
            endcase
            allow_idle <= (phase % 2 == 0) && (phase != RANDOM_PHASES - 1);
            program_gauge({23'($urandom), rev}, {8'($urandom), off}, ivl);
            // hold the result side off long enough to back the pipe up to the input
            if (phase == 1)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    0:       el = 24'd0;
                    1:       el = 24'($urandom);
                    default: el = 24'($urandom_range(0, (ivl > 24'h7FFFFF) ? 24'hFFFFFF
                                                                            : 2 * ivl));
                endcase
                // keep most averages inside the mapped band of the revision
                if ($urandom_range(0, 4) == 0)
                    smp = 12'($urandom);
                else if (rev)
                    smp = 12'($urandom_range(880, 1320));
                else
                    smp = 12'($urandom_range(620, 1020));
                send_tick(el, smp);
            end
        end

        tick_ch.valid <= 1'b0;
        wait_results_in();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (gauge.mismatches == 0 && gauge.pending() == 0)
            $display("tb_battery_gauge_averager OK");
        else
            $display("tb_battery_gauge_averager NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bga_pkg.sv
sv/bga_if.sv
sv/bga_gauge.sv
sv/battery_gauge_averager.sv
verif/bga_gauge_tb_pkg.sv
verif/tb_battery_gauge_averager.sv
